[rtl/english_text_letter_frequency_test_assert.svh]
// Assertion macros used by eltf_count.
`ifndef ENGLISH_TEXT_LETTER_FREQUENCY_TEST_ASSERT_SVH
`define ENGLISH_TEXT_LETTER_FREQUENCY_TEST_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define ELTF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Check that cons holds in the cycle after ante.
`define ELTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

[rtl/eltf_pkg.sv]
package eltf_pkg;

  localparam int MAX_LENGTH   = 1024;
  localparam int CNT_W        = $clog2(MAX_LENGTH + 1);
  localparam int NUM_LETTERS  = 13;
  localparam int NUM_SYMBOLS  = 5;
  localparam int SUM_W        = CNT_W + 3;
  localparam int PROD_W       = SUM_W + 4;
  localparam int MIN_BYTES    = 50;
  localparam int VOWEL_FACTOR = 5;
  localparam int BAD_FACTOR   = 5;
  localparam int RARE_FACTOR  = 10;

  localparam logic [7:0] FOLD_BIT   = 8'h20;
  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] FORM_FEED  = 8'h0C;
  localparam logic [7:0] TAB        = 8'h09;
  localparam logic [7:0] SPACE      = 8'h20;

  localparam int IDX_A = 0;
  localparam int IDX_E = 1;
  localparam int IDX_I = 2;
  localparam int IDX_O = 3;
  localparam int IDX_U = 4;
  localparam int IDX_T = 5;
  localparam int IDX_N = 6;
  localparam int IDX_V = 7;
  localparam int IDX_J = 8;
  localparam int IDX_K = 9;
  localparam int IDX_Q = 10;
  localparam int IDX_X = 11;
  localparam int IDX_Z = 12;

  localparam int SYM_SPACE = 0;
  localparam int SYM_SEMI  = 1;
  localparam int SYM_LT    = 2;
  localparam int SYM_GT    = 3;
  localparam int SYM_SLASH = 4;

  localparam logic [NUM_LETTERS-1:0][7:0] LETTER_CHARS = {
    "z", "x", "q", "k", "j", "v", "n", "t", "u", "o", "i", "e", "a"
  };
  localparam logic [NUM_SYMBOLS-1:0][7:0] SYMBOL_CHARS = {"/", ">", "<", ";", " "};

  typedef struct packed {
    logic [NUM_LETTERS-1:0][CNT_W-1:0] letters;
    logic [NUM_SYMBOLS-1:0][CNT_W-1:0] symbols;
    logic [CNT_W-1:0]                  punct;
    logic [CNT_W-1:0]                  bad;
    logic [CNT_W-1:0]                  bytes;
  } cnt_t;

  function automatic logic is_punct(input logic [7:0] b);
    return (b == ".") || (b == ",") || (b == ")") || (b == "%") ||
           (b == ";") || (b == ":") || (b == "?");
  endfunction

  function automatic logic is_gap(input logic [7:0] b);
    return (b == SPACE) || (b == FORM_FEED) || (b == TAB) || (b == NEWLINE);
  endfunction

endpackage

[rtl/eltf_count.sv]
`include "english_text_letter_frequency_test_assert.svh"

module eltf_count
  import eltf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       snap_valid_o,
  output cnt_t       snap_o
);

  cnt_t       cnt_q, cnt_d, snap_q;
  logic       pend_q, pend_d;
  logic       snap_valid_q;
  logic       active;
  logic [7:0] folded;

  assign active = cnt_q.bytes < CNT_W'(MAX_LENGTH);
  assign folded = byte_i | FOLD_BIT;

  always_comb begin
    cnt_d  = cnt_q;
    pend_d = pend_q;
    if (active) begin
      cnt_d.bytes = cnt_q.bytes + CNT_W'(1);
      if (pend_q && !is_gap(byte_i)) begin
        cnt_d.bad = cnt_q.bad + CNT_W'(1);
      end
      pend_d = 1'b0;
      if (!byte_i[7]) begin
        for (int k = 0; k < NUM_LETTERS; k++) begin
          if (folded == LETTER_CHARS[k]) begin
            cnt_d.letters[k] = cnt_q.letters[k] + CNT_W'(1);
          end
        end
        for (int k = 0; k < NUM_SYMBOLS; k++) begin
          if (folded == SYMBOL_CHARS[k]) begin
            cnt_d.symbols[k] = cnt_q.symbols[k] + CNT_W'(1);
          end
        end
      end
      if (is_punct(byte_i)) begin
        cnt_d.punct = cnt_q.punct + CNT_W'(1);
        pend_d      = !last_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      snap_valid_q <= 1'b0;
    end else if (en_i) begin
      snap_valid_q <= valid_i && last_i;
      if (valid_i) begin
        if (last_i) begin
          cnt_q  <= '0;
          pend_q <= 1'b0;
        end else begin
          cnt_q  <= cnt_d;
          pend_q <= pend_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i && last_i) begin
      snap_q <= cnt_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  `ELTF_ASSERT_SAME(a_bytes_bounded, clk_i, rst_ni, 1'b1, cnt_q.bytes <= CNT_W'(MAX_LENGTH))
  `ELTF_ASSERT_SAME(a_bad_le_punct, clk_i, rst_ni, 1'b1, cnt_q.bad <= cnt_q.punct)
  `ELTF_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, en_i && valid_i && last_i,
                    cnt_q.bytes == '0 && !pend_q && snap_valid_q)
  `ELTF_ASSERT_NEXT(a_snap_hold, clk_i, rst_ni, snap_valid_q && !en_i, snap_valid_q)

endmodule

[rtl/eltf_judge.sv]
module eltf_judge
  import eltf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic snap_valid_i,
  input  cnt_t snap_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output logic verdict_o
);

  logic [SUM_W-1:0]  vowels, common, rare, tags;
  logic [CNT_W-1:0]  e_cnt, non_space;
  logic [PROD_W-1:0] vowels_x, rare_x, bad_x, semi_x;
  logic              pass;
  logic              out_valid_q, verdict_q;

  always_comb begin
    e_cnt     = snap_i.letters[IDX_E];
    non_space = snap_i.bytes - snap_i.symbols[SYM_SPACE];
    vowels    = SUM_W'(snap_i.letters[IDX_A]) + SUM_W'(e_cnt) +
                SUM_W'(snap_i.letters[IDX_I]) + SUM_W'(snap_i.letters[IDX_O]) +
                SUM_W'(snap_i.letters[IDX_U]);
    common    = SUM_W'(e_cnt) + SUM_W'(snap_i.letters[IDX_T]) +
                SUM_W'(snap_i.letters[IDX_A]) + SUM_W'(snap_i.letters[IDX_I]) +
                SUM_W'(snap_i.letters[IDX_O]) + SUM_W'(snap_i.letters[IDX_N]);
    rare      = SUM_W'(snap_i.letters[IDX_V]) + SUM_W'(snap_i.letters[IDX_J]) +
                SUM_W'(snap_i.letters[IDX_K]) + SUM_W'(snap_i.letters[IDX_Q]) +
                SUM_W'(snap_i.letters[IDX_X]) + SUM_W'(snap_i.letters[IDX_Z]);
    tags      = SUM_W'(snap_i.symbols[SYM_LT]) + SUM_W'(snap_i.symbols[SYM_GT]) +
                SUM_W'(snap_i.symbols[SYM_SLASH]);
    vowels_x  = PROD_W'(vowels) * PROD_W'(VOWEL_FACTOR);
    rare_x    = PROD_W'(rare) * PROD_W'(RARE_FACTOR);
    bad_x     = PROD_W'(snap_i.bad) * PROD_W'(BAD_FACTOR);
    semi_x    = PROD_W'(snap_i.symbols[SYM_SEMI]) << 1;

    if (snap_i.bytes < CNT_W'(MIN_BYTES)) begin
      pass = 1'b0;
    end else if (bad_x > PROD_W'(snap_i.punct)) begin
      pass = 1'b0;
    end else if (semi_x > PROD_W'(e_cnt)) begin
      pass = 1'b0;
    end else if (tags > SUM_W'(e_cnt)) begin
      pass = 1'b0;
    end else begin
      pass = (vowels_x >= PROD_W'(non_space)) && (PROD_W'(common) >= rare_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i && snap_valid_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && snap_valid_i) begin
      verdict_q <= pass;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

[rtl/english_text_letter_frequency_test.sv]
// Verdict path: input register, then snapshot register, then output verdict register.
// Throughput: one byte per cycle while not stalled; counters update per byte up to MAX_LENGTH.
// Input stalls only while a verdict waits behind an unread result.
// Reset: rst_ni, asynchronous, active low, clears all counters and valid flags.
module english_text_letter_frequency_test
  import eltf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] is_english, [7:1] zero
);

  logic       en;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       snap_valid;
  cnt_t       snap;
  logic       verdict;

  assign en            = !(snap_valid && m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  eltf_count u_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_q),
    .byte_i       (in_byte_q),
    .last_i       (in_last_q),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  eltf_judge u_judge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .verdict_o    (verdict)
  );

  assign m_axis_tdata = {7'b0, verdict};

endmodule

[tb/english_verdict_checker.sv]
`timescale 1ns / 100ps

module english_verdict_checker
  import eltf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [0] is_english, [7:1] zero
  output int         fail_count_o,
  output int         pending_o
);

  logic [CNT_W-1:0] letter_cnt [NUM_LETTERS];
  logic [CNT_W-1:0] symbol_cnt [NUM_SYMBOLS];
  logic [CNT_W-1:0] punct_cnt;
  logic [CNT_W-1:0] bad_cnt;
  logic [CNT_W-1:0] byte_cnt;
  logic             punct_open;
  logic             verdict_q [$];
  logic [7:0]       exp_data;

  function automatic logic punct_byte(input logic [7:0] b);
    return (b == ".") || (b == ",") || (b == ")") || (b == "%") ||
           (b == ";") || (b == ":") || (b == "?");
  endfunction

  function automatic logic gap_byte(input logic [7:0] b);
    return (b == SPACE) || (b == FORM_FEED) || (b == TAB) || (b == NEWLINE);
  endfunction

  task automatic clear_counts();
    for (int k = 0; k < NUM_LETTERS; k++) letter_cnt[k] = '0;
    for (int k = 0; k < NUM_SYMBOLS; k++) symbol_cnt[k] = '0;
    punct_cnt  = '0;
    bad_cnt    = '0;
    byte_cnt   = '0;
    punct_open = 1'b0;
  endtask

  function automatic logic judge_text();
    int e;
    int vowels;
    int common;
    int rare;
    e = int'(letter_cnt[IDX_E]);
    if (int'(byte_cnt) < MIN_BYTES) return 1'b0;
    if (int'(bad_cnt) * BAD_FACTOR > int'(punct_cnt)) return 1'b0;
    if (2 * int'(symbol_cnt[SYM_SEMI]) > e) return 1'b0;
    if (int'(symbol_cnt[SYM_LT]) + int'(symbol_cnt[SYM_GT]) +
        int'(symbol_cnt[SYM_SLASH]) > e) return 1'b0;
    vowels = int'(letter_cnt[IDX_A]) + e + int'(letter_cnt[IDX_I]) +
             int'(letter_cnt[IDX_O]) + int'(letter_cnt[IDX_U]);
    common = e + int'(letter_cnt[IDX_T]) + int'(letter_cnt[IDX_A]) +
             int'(letter_cnt[IDX_I]) + int'(letter_cnt[IDX_O]) + int'(letter_cnt[IDX_N]);
    rare   = int'(letter_cnt[IDX_V]) + int'(letter_cnt[IDX_J]) + int'(letter_cnt[IDX_K]) +
             int'(letter_cnt[IDX_Q]) + int'(letter_cnt[IDX_X]) + int'(letter_cnt[IDX_Z]);
    return (vowels * VOWEL_FACTOR >= int'(byte_cnt) - int'(symbol_cnt[SYM_SPACE])) &&
           (common >= RARE_FACTOR * rare);
  endfunction

  task automatic tally_byte(input logic [7:0] b, input logic fin);
    logic [7:0] f;
    if (int'(byte_cnt) < MAX_LENGTH) begin
      byte_cnt = byte_cnt + 1'b1;
      if (punct_open && !gap_byte(b)) bad_cnt = bad_cnt + 1'b1;
      punct_open = 1'b0;
      if (!b[7]) begin
        f = b | FOLD_BIT;
        for (int k = 0; k < NUM_LETTERS; k++) begin
          if (f == LETTER_CHARS[k]) letter_cnt[k] = letter_cnt[k] + 1'b1;
        end
        for (int k = 0; k < NUM_SYMBOLS; k++) begin
          if (f == SYMBOL_CHARS[k]) symbol_cnt[k] = symbol_cnt[k] + 1'b1;
        end
      end
      if (punct_byte(b)) begin
        punct_cnt = punct_cnt + 1'b1;
        if (!fin) punct_open = 1'b1;
      end
    end
    if (fin) begin
      verdict_q.push_back(judge_text());
      clear_counts();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (fail_count_o < 10) begin
      $display("verdict %s: expected %h, got %h", what, want, got);
    end
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_counts();
      verdict_q.delete();
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          note_mismatch("unexpected", 8'h00, m_axis_tdata);
        end else begin
          exp_data = {7'b0, verdict_q.pop_front()};
          if (m_axis_tdata !== exp_data) note_mismatch("mismatch", exp_data, m_axis_tdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready) tally_byte(s_axis_tdata, s_axis_tlast);
    end
    pending_o = verdict_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import eltf_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic       s_axis_tlast;   // last
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [0] is_english, [7:1] zero

  int         fail_count;
  int         pending;
  bit         gaps_on = 1'b1;
  bit         hold_off_req = 1'b0;
  int         sent_bytes = 0;
  logic [7:0] text_q [$];

  english_text_letter_frequency_test i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  english_verdict_checker i_verdict_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic string pick_word(input bit rare);
    if (rare && $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 7))
        0: return "jazz";
        1: return "quiz";
        2: return "vex";
        3: return "kiwi";
        4: return "jinx";
        5: return "zq";
        6: return "fox";
        default: return "quote";
      endcase
    end
    case ($urandom_range(0, 15))
      0: return "the";
      1: return "and";
      2: return "tea";
      3: return "into";
      4: return "note";
      5: return "eat";
      6: return "one";
      7: return "rain";
      8: return "tone";
      9: return "area";
      10: return "idea";
      11: return "onto";
      12: return "on";
      13: return "a";
      14: return "iota";
      default: return "union";
    endcase
  endfunction

  function automatic logic [7:0] pick_punct(input bit semi_heavy);
    if (semi_heavy && $urandom_range(0, 1) == 0) return ";";
    case ($urandom_range(0, 6))
      0: return ".";
      1: return ",";
      2: return ")";
      3: return "%";
      4: return ";";
      5: return ":";
      default: return "?";
    endcase
  endfunction

  function automatic logic [7:0] pick_gap();
    case ($urandom_range(0, 9))
      0: return TAB;
      1: return NEWLINE;
      2: return FORM_FEED;
      default: return SPACE;
    endcase
  endfunction

  task automatic build_prose(input int kind, input int target);
    string      w;
    logic [7:0] c;
    bit         tag;
    text_q.delete();
    while (text_q.size() < target) begin
      w   = pick_word(kind == 8);
      tag = (kind == 7) && ($urandom_range(0, 2) == 0);
      if (tag) text_q.push_back("<");
      for (int i = 0; i < w.len(); i++) begin
        c = w[i];
        if ($urandom_range(0, 7) == 0) c = c ^ FOLD_BIT;
        text_q.push_back(c);
      end
      if (tag) begin
        text_q.push_back("/");
        text_q.push_back(">");
      end
      if (kind == 9 && $urandom_range(0, 3) == 0) text_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) text_q.push_back(pick_punct(kind == 8));
      if ($urandom_range(0, 19) >= ((kind == 8) ? 6 : 1)) text_q.push_back(pick_gap());
    end
    while (text_q.size() > target) void'(text_q.pop_back());
    if ($urandom_range(0, 3) == 0) text_q[text_q.size() - 1] = ".";
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) push_byte(text_q[i], i == text_q.size() - 1);
    sent_bytes += text_q.size();
  endtask

  task automatic make_buffer(input int idx);
    int kind;
    kind = $urandom_range(0, 9);
    if (idx == 3) build_prose(9, MAX_LENGTH + 6);
    else if (kind == 6) begin
      text_q.delete();
      repeat ($urandom_range(1, 80)) text_q.push_back(8'($urandom_range(0, 255)));
    end else build_prose(kind, $urandom_range(30, 80));
  endtask

  initial begin
    logic [7:0] singles [6];
    int         nbuf;
    singles = '{8'h00, 8'hFF, 8'h2E, 8'h1B, 8'h7F, 8'h80};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (singles[i]) begin
      text_q = '{singles[i]};
      send_text();
    end
    text_q = '{8'h2E, 8'h78};
    send_text();
    text_q = '{8'h3B, 8'h09, 8'h3F};
    send_text();

    // hold the result side off while short buffers pile up
    hold_off_req = 1'b1;
    repeat (40) begin
      text_q.delete();
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
      send_text();
    end

    nbuf = 0;
    while (sent_bytes < 1300) begin
      make_buffer(nbuf);
      send_text();
      nbuf++;
    end

    gaps_on = 1'b0;
    repeat (2) begin
      make_buffer(nbuf);
      send_text();
      nbuf++;
    end
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
